// ===== rtl/dtt_pkg.sv =====
`timescale 1ns / 1ps

package dtt_pkg;

   // Operation codes carried on the command field of an item.
   typedef enum logic [2:0] {
      CMD_ADD      = 3'd0,
      CMD_REMOVE   = 3'd1,
      CMD_GET      = 3'd2,
      CMD_CONTAINS = 3'd3,
      CMD_CLEAR    = 3'd4
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_PRESENT = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_GET
   } state_type;

endpackage

// ===== rtl/dtt_mem.sv =====
`timescale 1ns / 1ps

module dtt_mem #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   // Simple dual-port storage: one write and one registered read per cycle.
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== rtl/dedup_tag_table.sv =====
`timescale 1ns / 1ps
// Clear, get outside the filled part, unused codes, and adds and lookups on an empty table
// answer in the cycle after the item is taken; get reads the entry into the memory output
// register and answers from it. Add, remove and contains scan the table at one entry per
// cycle until a hit or the end of the filled part; remove then shifts the later entries
// down at one entry per cycle. The single memory read port sets these rates.
// Reset clears the fill count and the sequencer; the receiver cannot stall results.

module dedup_tag_table #(
   parameter int DEPTH         = 64,
   parameter int TAG_WIDTH     = 32,
   parameter int PAYLOAD_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   // Command channel: an item is taken when start is high and busy is low.
   input  logic                       start,
   output logic                       busy,
   input  logic [2:0]                 req_command,
   input  logic [TAG_WIDTH-1:0]       req_tag_key,
   input  logic [PAYLOAD_WIDTH-1:0]   req_payload_in,
   input  logic [$clog2(DEPTH)-1:0]   req_position,
   // Result channel: each result is shown for exactly one cycle under rsp_valid.
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [$clog2(DEPTH)-1:0]   rsp_index_out,
   output logic [TAG_WIDTH-1:0]       rsp_tag_out,
   output logic [PAYLOAD_WIDTH-1:0]   rsp_payload_out,
   output logic [$clog2(DEPTH+1)-1:0] rsp_entry_total
);

   import dtt_pkg::*;

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = TAG_WIDTH + PAYLOAD_WIDTH;

   // Sequencer and captured item.
   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [TAG_WIDTH-1:0]     key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [IDX_W-1:0]         pos_ff, pos_in;

   // The fill count is the only table state that needs a reset: entries at or above it
   // are never used, so the memory itself is never cleared.
   logic [CNT_W-1:0]         fill_ff, fill_in;

   // Read pipeline: addr_ff is the next address to issue, pend_ff marks that the memory
   // output holds the entry at pend_addr_ff this cycle.
   logic [CNT_W-1:0]         addr_ff, addr_in;
   logic                     pend_ff, pend_in;
   logic [IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   logic [IDX_W-1:0]         where_ff, where_in;

   // Result registers.
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [TAG_WIDTH-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [PAYLOAD_WIDTH-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CNT_W-1:0]         rsp_total_ff, rsp_total_in;

   // Memory port.
   logic                     mem_wr_en;
   logic [IDX_W-1:0]         mem_wr_addr;
   logic [WORD_W-1:0]        mem_wr_data;
   logic [IDX_W-1:0]         mem_rd_addr;
   logic [WORD_W-1:0]        mem_rd_data;

   logic [TAG_WIDTH-1:0]     rd_tag;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;
   logic                     accept;
   logic                     issue;
   logic                     pend_last;

   assign accept    = start && (state_ff == S_IDLE);
   assign rd_tag    = mem_rd_data[WORD_W-1 -: TAG_WIDTH];
   assign rd_pay    = mem_rd_data[PAYLOAD_WIDTH-1:0];
   // A read is worth issuing only below the fill count.
   assign issue     = addr_ff < fill_ff;
   // The entry on the memory output is the last filled one.
   assign pend_last = (CNT_W'(pend_addr_ff) + CNT_W'(1)) == fill_ff;

   dtt_mem #(
      .WIDTH(WORD_W),
      .DEPTH(DEPTH)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      pos_ff        <= pos_in;
      addr_ff       <= addr_in;
      pend_addr_ff  <= pend_addr_in;
      where_ff      <= where_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_total_ff  <= rsp_total_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      pos_in        = pos_ff;
      fill_in       = fill_ff;
      addr_in       = addr_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      where_in      = where_ff;

      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_total_in  = rsp_total_ff;

      mem_wr_en     = 1'b0;
      mem_wr_addr   = fill_ff[IDX_W-1:0];
      mem_wr_data   = {key_ff, pay_ff};
      mem_rd_addr   = addr_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            // The get address goes to the memory straight from the port, so the entry
            // is on the memory output in the following cycle.
            mem_rd_addr = req_position;
            if (accept) begin
               cmd_in  = cmd_type'(req_command);
               key_in  = req_tag_key;
               pay_in  = req_payload_in;
               pos_in  = req_position;
               addr_in = '0;
               // Most immediate answers are a miss with nothing read; the arms below
               // override what differs.
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_MISSING;
               rsp_index_in  = '0;
               rsp_tag_in    = '0;
               rsp_pay_in    = '0;
               case (cmd_type'(req_command))
                  CMD_ADD: begin
                     if (fill_ff == '0) begin
                        // Empty table: the tag cannot be present, append at position zero.
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = '0;
                        mem_wr_data   = {req_tag_key, req_payload_in};
                        fill_in       = CNT_W'(1);
                        rsp_status_in = ST_DONE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  CMD_REMOVE, CMD_CONTAINS: begin
                     if (fill_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                     end
                  end
                  CMD_GET: begin
                     if (CNT_W'(req_position) < fill_ff) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_GET;
                     end
                  end
                  CMD_CLEAR: begin
                     fill_in       = '0;
                     rsp_status_in = ST_DONE;
                  end
                  default: begin
                  end
               endcase
               rsp_total_in = fill_in;
            end
         end

         S_GET: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_index_in  = pos_ff;
            rsp_tag_in    = rd_tag;
            rsp_pay_in    = rd_pay;
            rsp_total_in  = fill_ff;
            state_in      = S_IDLE;
         end

         S_SCAN: begin
            // Per cycle, at most one address is issued and one entry compared.
            if (issue) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff[IDX_W-1:0];
               addr_in      = addr_ff + CNT_W'(1);
            end
            if (pend_ff && (rd_tag == key_ff)) begin
               pend_in      = 1'b0;
               rsp_tag_in   = '0;
               rsp_pay_in   = '0;
               rsp_index_in = pend_addr_ff;
               where_in     = pend_addr_ff;
               case (cmd_ff)
                  CMD_ADD: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_PRESENT;
                     state_in      = S_IDLE;
                  end
                  CMD_REMOVE: begin
                     if (pend_last) begin
                        // The last entry goes without any shift.
                        fill_in       = fill_ff - CNT_W'(1);
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_DONE;
                        state_in      = S_IDLE;
                     end else begin
                        addr_in  = CNT_W'(pend_addr_ff) + CNT_W'(1);
                        state_in = S_SHIFT;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_DONE;
                     state_in      = S_IDLE;
                  end
               endcase
            end else if (pend_ff && pend_last) begin
               // The whole filled part was searched without a hit.
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_tag_in   = '0;
               rsp_pay_in   = '0;
               rsp_index_in = '0;
               state_in     = S_IDLE;
               if (cmd_ff == CMD_ADD) begin
                  if (fill_ff == CNT_W'(DEPTH)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = fill_ff[IDX_W-1:0];
                     mem_wr_data   = {key_ff, pay_ff};
                     rsp_index_in  = fill_ff[IDX_W-1:0];
                     fill_in       = fill_ff + CNT_W'(1);
                     rsp_status_in = ST_DONE;
                  end
               end else begin
                  rsp_status_in = ST_MISSING;
               end
            end
            rsp_total_in = fill_in;
         end

         S_SHIFT: begin
            // Entry j is read in one cycle and written to j-1 in the next, so the read
            // and the write never touch the same entry.
            if (issue) begin
               pend_in      = 1'b1;
               pend_addr_in = addr_ff[IDX_W-1:0];
               addr_in      = addr_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = pend_addr_ff - IDX_W'(1);
               mem_wr_data = mem_rd_data;
               if (pend_last) begin
                  pend_in       = 1'b0;
                  fill_in       = fill_ff - CNT_W'(1);
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_DONE;
                  rsp_index_in  = where_ff;
                  rsp_tag_in    = '0;
                  rsp_pay_in    = '0;
                  state_in      = S_IDLE;
               end
            end
            rsp_total_in = fill_in;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_index_out   = rsp_index_ff;
   assign rsp_tag_out     = rsp_tag_ff;
   assign rsp_payload_out = rsp_pay_ff;
   assign rsp_entry_total = rsp_total_ff;

`ifndef SYNTHESIS
   // The table never holds more entries than it has room for.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond table depth");

   // A result only follows an accepted item or a busy cycle.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept || busy))
      else $error("result without an item");

   // Every multi-cycle operation ends with exactly its result.
   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && $past(!reset)) |-> rsp_valid_ff)
      else $error("operation ended without a result");

   // The table is only written while an item is being worked on.
   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (accept || busy))
      else $error("memory write while idle");
`endif

endmodule
